[rtl/core/nnis_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nnis_pkg;

   // Fixed field widths
   localparam int CHAN_BITS     = 8;
   localparam int REG_BITS      = 13;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Defaults for the top-level parameters
   localparam int DEFAULT_STORE_PIXELS = 1048576;
   localparam int DEFAULT_DIM_BITS     = 12;
   localparam int DEFAULT_QUEUE_DEPTH  = 4;

   // Register values after reset
   localparam logic [REG_BITS-1:0] RESET_SRC_WIDTH  = 13'd1280;
   localparam logic [REG_BITS-1:0] RESET_SRC_HEIGHT = 13'd720;
   localparam logic [REG_BITS-1:0] RESET_DST_WIDTH  = 13'd720;
   localparam logic [REG_BITS-1:0] RESET_DST_HEIGHT = 13'd480;

   // Item operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH,
      REG_SRC_HEIGHT,
      REG_DST_WIDTH,
      REG_DST_HEIGHT
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_DIVIDE,
      ST_WAIT,
      ST_SCALE,
      ST_RUN
   } setup_state_type;

   typedef struct packed {
      logic                 operation;
      logic [CHAN_BITS-1:0] in_blue;
      logic [CHAN_BITS-1:0] in_green;
      logic [CHAN_BITS-1:0] in_red;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] out_blue;
      logic [CHAN_BITS-1:0] out_green;
      logic [CHAN_BITS-1:0] out_red;
      logic                 frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
   } pixel_type;

   // Command flags passed from front to back
   typedef struct packed {
      logic load;
      logic last;
      logic in_store;
   } cmd_ctl_type;

endpackage

`default_nettype wire

[rtl/core/nnis_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

module nnis_divider
   import nnis_pkg::*;
#(
   parameter int W = DEFAULT_DIM_BITS + 1
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CNTW = $clog2(W + 1);

   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    div_ff, div_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            busy_ff, busy_in;
   logic [W:0]      trial;
   logic            fits;

   // One quotient bit per cycle, restoring
   always_comb begin
      trial    = {rem_ff, quo_ff[W-1]};
      fits     = trial >= {1'b0, div_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
         count_in = CNTW'(W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? W'(trial - {1'b0, div_ff}) : trial[W-1:0];
         quo_in   = {quo_ff[W-2:0], fits};
         count_in = count_ff - CNTW'(1);
         busy_in  = count_ff != CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[rtl/core/nnis_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module nnis_front
   import nnis_pkg::*;
#(
   parameter int STORE_PIXELS = DEFAULT_STORE_PIXELS,
   parameter int DIM_BITS     = DEFAULT_DIM_BITS
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [CSR_ADDR_BITS-1:0]         paddr,
   input  logic [CSR_DATA_BITS-1:0]         pwdata,
   output logic [CSR_DATA_BITS-1:0]         prdata,
   output logic                             pready,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  req_payload_type                  req_data,
   output logic                             push_valid,
   input  logic                             push_ready,
   output cmd_ctl_type                      push_ctl,
   output pixel_type                        push_pixel,
   output logic [$clog2(STORE_PIXELS)-1:0]  push_addr
);

   localparam int DW   = DIM_BITS + 1;
   localparam int FW   = 2 * DIM_BITS + 2;
   localparam int SA   = $clog2(STORE_PIXELS);
   localparam int CMPW = (FW > SA + 1) ? FW : SA + 1;
   localparam int MW   = (REG_BITS > DW) ? REG_BITS : DW;
   localparam logic [MW-1:0]   DIM_MAX   = MW'(1) << DIM_BITS;
   localparam logic [CMPW-1:0] STORE_LIM = CMPW'(STORE_PIXELS);

   // Force a register value into 1 .. 2^DIM_BITS
   function automatic logic [DW-1:0] clamp_dim(input logic [REG_BITS-1:0] v);
      logic [MW-1:0] x;
      x = MW'(v);
      if (x == '0) begin
         x = MW'(1);
      end else if (x > DIM_MAX) begin
         x = DIM_MAX;
      end
      return x[DW-1:0];
   endfunction

   setup_state_type state_ff, state_in;
   logic            div_start;

   logic [DW-1:0] sw_ff, sw_in, sh_ff, sh_in, dw_ff, dw_in, dh_ff, dh_in;
   logic [FW-1:0] frame_ff, frame_in, row_step_ff, row_step_in;
   logic [FW-1:0] load_pos_ff, load_pos_in, row_base_ff, row_base_in;
   logic [DIM_BITS-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [DIM_BITS-1:0] scol_ff, scol_in, crem_ff, crem_in, rrem_ff, rrem_in;

   logic          row_busy, col_busy;
   logic [DW-1:0] row_quo, row_rem, col_quo, col_rem;

   logic          cfg_write;
   reg_index_type cfg_index;
   logic [DW-1:0] cfg_dim;
   logic          accept;

   logic [FW-1:0] load_next, fetch_addr;
   logic          load_wrap;
   logic [DW-1:0] col_pos_next, row_pos_next, csum, rsum, scol_next;
   logic          col_wrap, row_wrap, ccarry, rcarry;

   nnis_divider #(.W(DW)) u_row_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sh_ff),
      .divisor   (dh_ff),
      .busy      (row_busy),
      .quotient  (row_quo),
      .remainder (row_rem)
   );

   nnis_divider #(.W(DW)) u_col_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sw_ff),
      .divisor   (dw_ff),
      .busy      (col_busy),
      .quotient  (col_quo),
      .remainder (col_rem)
   );

   // Register port decode
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign cfg_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign cfg_dim   = clamp_dim(pwdata[REG_BITS-1:0]);

   always_comb begin
      case (cfg_index)
         REG_SRC_WIDTH:  prdata = CSR_DATA_BITS'(sw_ff);
         REG_SRC_HEIGHT: prdata = CSR_DATA_BITS'(sh_ff);
         REG_DST_WIDTH:  prdata = CSR_DATA_BITS'(dw_ff);
         REG_DST_HEIGHT: prdata = CSR_DATA_BITS'(dh_ff);
         default:        prdata = '0;
      endcase
   end

   // Setup sequencer: step constants, then accept items
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_DIVIDE: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (!row_busy && !col_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_RUN;
         ST_RUN:   state_in = ST_RUN;
         default:  state_in = ST_DIVIDE;
      endcase
      if (cfg_write) begin
         state_in = ST_DIVIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DIVIDE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Accept items only into a free queue slot once set up
   assign push_valid = req_valid && (state_ff == ST_RUN);
   assign req_ready  = (state_ff == ST_RUN) && push_ready;
   assign accept     = req_valid && req_ready;

   // Load position and fetch address
   assign load_next  = load_pos_ff + FW'(1);
   assign load_wrap  = load_next >= frame_ff;
   assign fetch_addr = row_base_ff + FW'(scol_ff);

   // Column and row step accumulators
   assign col_pos_next = DW'(out_col_ff) + DW'(1);
   assign row_pos_next = DW'(out_row_ff) + DW'(1);
   assign col_wrap     = col_pos_next >= dw_ff;
   assign row_wrap     = row_pos_next >= dh_ff;
   assign csum         = DW'(crem_ff) + col_rem;
   assign rsum         = DW'(rrem_ff) + row_rem;
   assign ccarry       = csum >= dw_ff;
   assign rcarry       = rsum >= dh_ff;
   assign scol_next    = DW'(scol_ff) + col_quo + DW'(ccarry);

   // Classify the item into a queue command
   always_comb begin
      push_pixel.blue  = req_data.in_blue;
      push_pixel.green = req_data.in_green;
      push_pixel.red   = req_data.in_red;
      if (req_data.operation == OP_LOAD) begin
         push_ctl.load     = 1'b1;
         push_ctl.last     = 1'b0;
         push_ctl.in_store = CMPW'(load_pos_ff) < STORE_LIM;
         push_addr         = load_pos_ff[SA-1:0];
      end else begin
         push_ctl.load     = 1'b0;
         push_ctl.last     = col_wrap && row_wrap;
         push_ctl.in_store = CMPW'(fetch_addr) < STORE_LIM;
         push_addr         = fetch_addr[SA-1:0];
      end
   end

   // Next values for registers, counters and step constants
   always_comb begin
      sw_in       = sw_ff;
      sh_in       = sh_ff;
      dw_in       = dw_ff;
      dh_in       = dh_ff;
      frame_in    = frame_ff;
      row_step_in = row_step_ff;
      load_pos_in = load_pos_ff;
      row_base_in = row_base_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      scol_in     = scol_ff;
      crem_in     = crem_ff;
      rrem_in     = rrem_ff;

      if (state_ff == ST_SCALE) begin
         frame_in    = FW'(sw_ff) * FW'(sh_ff);
         row_step_in = FW'(row_quo) * FW'(sw_ff);
      end

      if (cfg_write) begin
         case (cfg_index)
            REG_SRC_WIDTH:  sw_in = cfg_dim;
            REG_SRC_HEIGHT: sh_in = cfg_dim;
            REG_DST_WIDTH:  dw_in = cfg_dim;
            REG_DST_HEIGHT: dh_in = cfg_dim;
            default:        sw_in = sw_ff;
         endcase
         load_pos_in = '0;
         row_base_in = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         scol_in     = '0;
         crem_in     = '0;
         rrem_in     = '0;
      end else if (accept) begin
         if (req_data.operation == OP_LOAD) begin
            load_pos_in = load_wrap ? '0 : load_next;
         end else if (!col_wrap) begin
            out_col_in = col_pos_next[DIM_BITS-1:0];
            scol_in    = scol_next[DIM_BITS-1:0];
            crem_in    = ccarry ? DIM_BITS'(csum - dw_ff) : csum[DIM_BITS-1:0];
         end else begin
            out_col_in = '0;
            scol_in    = '0;
            crem_in    = '0;
            if (row_wrap) begin
               out_row_in  = '0;
               row_base_in = '0;
               rrem_in     = '0;
            end else begin
               out_row_in  = row_pos_next[DIM_BITS-1:0];
               row_base_in = row_base_ff + row_step_ff + (rcarry ? FW'(sw_ff) : '0);
               rrem_in     = rcarry ? DIM_BITS'(rsum - dh_ff) : rsum[DIM_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff       <= clamp_dim(RESET_SRC_WIDTH);
         sh_ff       <= clamp_dim(RESET_SRC_HEIGHT);
         dw_ff       <= clamp_dim(RESET_DST_WIDTH);
         dh_ff       <= clamp_dim(RESET_DST_HEIGHT);
         load_pos_ff <= '0;
         row_base_ff <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         scol_ff     <= '0;
         crem_ff     <= '0;
         rrem_ff     <= '0;
      end else begin
         sw_ff       <= sw_in;
         sh_ff       <= sh_in;
         dw_ff       <= dw_in;
         dh_ff       <= dh_in;
         load_pos_ff <= load_pos_in;
         row_base_ff <= row_base_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         scol_ff     <= scol_in;
         crem_ff     <= crem_in;
         rrem_ff     <= rrem_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      row_step_ff <= row_step_in;
   end

`ifndef NO_ASSERTIONS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (DW'(out_col_ff) < dw_ff) && (DW'(out_row_ff) < dh_ff))
      else $error("destination position outside the frame");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (DW'(crem_ff) < dw_ff) && (DW'(rrem_ff) < dh_ff))
      else $error("step remainder not below its divisor");

   a_load_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> load_pos_ff < frame_ff)
      else $error("load position past the source frame");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> state_ff == ST_DIVIDE && load_pos_ff == '0 &&
                    out_col_ff == '0 && out_row_ff == '0)
      else $error("register write did not restart both frames");
`endif

endmodule

`default_nettype wire

[rtl/core/nnis_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module nnis_queue
   import nnis_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/nnis_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module nnis_back
   import nnis_pkg::*;
#(
   parameter int STORE_PIXELS = DEFAULT_STORE_PIXELS
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  cmd_ctl_type                      pop_ctl,
   input  pixel_type                        pop_pixel,
   input  logic [$clog2(STORE_PIXELS)-1:0]  pop_addr,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rsp_payload_type                  rsp_data
);

   pixel_type       store_mem [STORE_PIXELS];
   pixel_type       rd_ff;
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_last_ff, s1_keep_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            s1_adv, do_pop;

   // Loads retire at the memory; fetches wait for the read stage
   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign pop_ready = pop_ctl.load || !s1_valid_ff || s1_adv;
   assign do_pop    = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_pop && pop_ctl.load && pop_ctl.in_store) begin
         store_mem[pop_addr] <= pop_pixel;
      end
      if (do_pop && !pop_ctl.load) begin
         rd_ff <= store_mem[pop_addr];
      end
   end

   // Read stage and output register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (do_pop && !pop_ctl.load) begin
         s1_valid_in = 1'b1;
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_adv) begin
         out_valid_in      = 1'b1;
         out_in.out_blue   = s1_keep_ff ? rd_ff.blue  : '0;
         out_in.out_green  = s1_keep_ff ? rd_ff.green : '0;
         out_in.out_red    = s1_keep_ff ? rd_ff.red   : '0;
         out_in.frame_last = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold command flags alongside the read data
   always_ff @(posedge clock) begin
      if (do_pop && !pop_ctl.load) begin
         s1_last_ff <= pop_ctl.last;
         s1_keep_ff <= pop_ctl.in_store;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

[rtl/core/nearest_neighbor_image_scaler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Content
// req_      in         req_valid/req_ready    load one source pixel or fetch next output
// rsp_      out        rsp_valid/rsp_ready    destination pixel and end-of-frame flag
// csr_      in         psel/penable/pready    four size registers, APB-style, 32-bit data
//
// Steady state: one item per clock unless a result stalls. A fetch result passes the
// queue, read stage and output register. After reset and each register write, two
// serial dividers and two multiplies set the step constants; req_ready is low meanwhile.
// Reset is synchronous; the frame store holds no reset value and is not cleared.
// A stalled result stalls the read stage, then the command queue, then req_ready.

module nearest_neighbor_image_scaler_unit
   import nnis_pkg::*;
#(
   parameter int STORE_PIXELS = DEFAULT_STORE_PIXELS,
   parameter int DIM_BITS     = DEFAULT_DIM_BITS,
   parameter int QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int SA = $clog2(STORE_PIXELS);
   localparam int QW = $bits(cmd_ctl_type) + $bits(pixel_type) + SA;

   logic          push_valid, push_ready, pop_valid, pop_ready;
   cmd_ctl_type   push_ctl, pop_ctl;
   pixel_type     push_pixel, pop_pixel;
   logic [SA-1:0] push_addr, pop_addr;
   logic [QW-1:0] push_word, pop_word;

   nnis_front #(
      .STORE_PIXELS (STORE_PIXELS),
      .DIM_BITS     (DIM_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ctl   (push_ctl),
      .push_pixel (push_pixel),
      .push_addr  (push_addr)
   );

   // Pack commands for the queue
   assign push_word                      = {push_ctl, push_pixel, push_addr};
   assign {pop_ctl, pop_pixel, pop_addr} = pop_word;

   nnis_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_word)
   );

   nnis_back #(
      .STORE_PIXELS (STORE_PIXELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_ctl   (pop_ctl),
      .pop_pixel (pop_pixel),
      .pop_addr  (pop_addr),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
